[rtl/core/imgscl_pkg.sv]
// Shared types and constants for the image scaler.
package imgscl_pkg;

  // Field widths
  localparam int DIM_W    = 9;   // size registers
  localparam int POS_W    = 8;   // coordinates on the stream
  localparam int CH_W     = 8;   // one color channel
  localparam int CHANNELS = 4;   // red, green, blue, alpha
  localparam int PIX_W    = CH_W * CHANNELS;

  // Fixed-point step and cursor (48 fraction bits)
  localparam int FRAC_SHIFT = 48;
  localparam int STEP_W     = DIM_W + FRAC_SHIFT;      // size << 48 fits here
  localparam int CUR_W      = STEP_W + 1;              // half step + pos * step
  localparam int IDX_W      = CUR_W - FRAC_SHIFT;      // integer part of a cursor
  localparam int T_W        = CUR_W - 32;              // cursor >> 32
  localparam int FR_W       = 16;                      // blend fraction
  localparam int WT_W       = 2 * FR_W + 1;            // product of two weights, up to 2^32
  localparam int ACC_W      = WT_W + CH_W - 1;         // channel * weight, sums to 255 << 32

  localparam logic [STEP_W-1:0] STEP_ONE =
    {{(STEP_W-FRAC_SHIFT-1){1'b0}}, 1'b1, {FRAC_SHIFT{1'b0}}};
  localparam logic [T_W-1:0]  HALF_TEXEL = T_W'(32'h8000);
  localparam logic [FR_W:0]   WEIGHT_ONE = {1'b1, {FR_W{1'b0}}};

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SRC_WIDTH   = 3'd0;
  localparam cfg_idx_t REG_SRC_HEIGHT  = 3'd1;
  localparam cfg_idx_t REG_DST_WIDTH   = 3'd2;
  localparam cfg_idx_t REG_DST_HEIGHT  = 3'd3;
  localparam cfg_idx_t REG_FILTER_MODE = 3'd4;

  // Item kinds and filter modes
  localparam logic FUNC_LOAD       = 1'b0;
  localparam logic FUNC_SAMPLE     = 1'b1;
  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // Request to a step divider: (num << 48) / den
  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] num;
    logic [DIM_W-1:0] den;
  } div_req_t;

endpackage

[rtl/core/imgscl_step_div.sv]
// Bit-serial divider that derives one fixed-point scale step.
module imgscl_step_div (
  input  logic                          clk,
  input  logic                          rst,
  input  imgscl_pkg::div_req_t          req,
  output logic                          busy,
  output logic [imgscl_pkg::STEP_W-1:0] quo
);

  localparam int CNT_W = $clog2(imgscl_pkg::STEP_W);

  logic [CNT_W-1:0]              cnt;
  logic [imgscl_pkg::DIM_W-1:0]  rem;
  logic [imgscl_pkg::DIM_W-1:0]  num_sh;
  logic [imgscl_pkg::DIM_W-1:0]  den;
  logic [imgscl_pkg::DIM_W:0]    rem_sh;
  logic [imgscl_pkg::DIM_W:0]    rem_sub;
  logic                          fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem, num_sh[imgscl_pkg::DIM_W-1]};
    fits    = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  // Dividend is num followed by 48 zero bits: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      quo  <= imgscl_pkg::STEP_ONE;   // all sizes are 1 after reset
    end else if (req.start) begin
      busy   <= 1'b1;
      cnt    <= CNT_W'(imgscl_pkg::STEP_W - 1);
      rem    <= '0;
      num_sh <= req.num;
      den    <= req.den;
      quo    <= '0;
    end else if (busy) begin
      rem    <= fits ? rem_sub[imgscl_pkg::DIM_W-1:0] : rem_sh[imgscl_pkg::DIM_W-1:0];
      num_sh <= {num_sh[imgscl_pkg::DIM_W-2:0], 1'b0};
      quo    <= {quo[imgscl_pkg::STEP_W-2:0], fits};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[rtl/core/image_scaler_nearest_bilinear.sv]
// Image scaler top level: source pixel store, cursor pipeline and blend.
//
// Load items (tuser = 0) write one RGBA8 pixel into an on-chip store of
// MAX_DIM x MAX_DIM words; sample items (tuser = 1) return one rescaled
// pixel, by nearest neighbour or bilinear filtering. The store has a single
// synchronous port shared by loads and reads, so a load or a nearest sample
// makes one access of that port and a bilinear sample makes four (one per
// neighbour). Loads and nearest samples are taken at 1 item per cycle when
// no step division runs and the output queue has room; a bilinear sample
// holds the port for all four reads. Items pass stages 1 to 4, the read,
// product and accumulate stages, then results wait in an 8-entry output
// queue; samples outside the destination or with a zero size give no result.
// Writing a size register starts a bit-serial division of the x and y steps,
// during which no item is accepted. Pixels must be loaded before they are
// sampled; the store is not cleared.
module image_scaler_nearest_bilinear #(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, in_red, in_green, in_blue, in_alpha
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
  input  logic        cfg_we,
  input  logic [imgscl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imgscl_pkg::DIM_W-1:0]     cfg_data
);

  localparam int CW     = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int QDEPTH = 8;
  localparam int QW     = $clog2(QDEPTH);
  localparam int QCW    = QW + 1;

  typedef struct packed {
    logic [CW-1:0]               i1;
    logic [CW-1:0]               i2;
    logic [imgscl_pkg::FR_W-1:0] frac;
  } axis_t;

  // Size register saturated to the store size
  function automatic logic [imgscl_pkg::DIM_W-1:0] eff_dim(
    input logic [imgscl_pkg::DIM_W-1:0] v
  );
    eff_dim = (int'(v) > MAX_DIM) ? imgscl_pkg::DIM_W'(MAX_DIM) : v;
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    mem_addr = AW'(y * MAX_DIM) + AW'(x);
  endfunction

  // Cursor to neighbour indices and fraction for one axis
  function automatic axis_t split_axis(
    input logic [imgscl_pkg::CUR_W-1:0] cur,
    input logic [imgscl_pkg::DIM_W-1:0] size,
    input logic                         bilinear
  );
    logic [imgscl_pkg::T_W-1:0]   t;
    logic [imgscl_pkg::T_W-1:0]   tb;
    logic [imgscl_pkg::IDX_W-1:0] lim;
    logic [imgscl_pkg::IDX_W-1:0] a;
    logic [imgscl_pkg::IDX_W-1:0] b;
    axis_t                        r;
    lim = imgscl_pkg::IDX_W'(size) - 1'b1;
    t   = cur[imgscl_pkg::CUR_W-1:32];
    tb  = (t > imgscl_pkg::HALF_TEXEL) ? t - imgscl_pkg::HALF_TEXEL : '0;
    if (bilinear) begin
      a      = tb[imgscl_pkg::T_W-1:imgscl_pkg::FR_W];
      r.frac = tb[imgscl_pkg::FR_W-1:0];
    end else begin
      a      = cur[imgscl_pkg::CUR_W-1:imgscl_pkg::FRAC_SHIFT];
      r.frac = '0;
    end
    if (a > lim) a = lim;
    b = a + 1'b1;
    if (b > lim) b = lim;
    r.i1 = CW'(a);
    r.i2 = CW'(b);
    split_axis = r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [imgscl_pkg::DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic                         filter_mode;
  logic                         div_kick;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= imgscl_pkg::DIM_W'(1);
      src_height  <= imgscl_pkg::DIM_W'(1);
      dst_width   <= imgscl_pkg::DIM_W'(1);
      dst_height  <= imgscl_pkg::DIM_W'(1);
      filter_mode <= imgscl_pkg::FILTER_BILINEAR;
      div_kick    <= 1'b0;
    end else begin
      div_kick <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          imgscl_pkg::REG_SRC_WIDTH: begin
            src_width <= cfg_data;
            div_kick  <= 1'b1;
          end
          imgscl_pkg::REG_SRC_HEIGHT: begin
            src_height <= cfg_data;
            div_kick   <= 1'b1;
          end
          imgscl_pkg::REG_DST_WIDTH: begin
            dst_width <= cfg_data;
            div_kick  <= 1'b1;
          end
          imgscl_pkg::REG_DST_HEIGHT: begin
            dst_height <= cfg_data;
            div_kick   <= 1'b1;
          end
          imgscl_pkg::REG_FILTER_MODE: begin
            filter_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  logic [imgscl_pkg::DIM_W-1:0] sw, sh, dw, dh;
  logic                         sizes_ok;

  assign sw       = eff_dim(src_width);
  assign sh       = eff_dim(src_height);
  assign dw       = eff_dim(dst_width);
  assign dh       = eff_dim(dst_height);
  assign sizes_ok = (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0);

  // Step dividers, restarted after every size write
  imgscl_pkg::div_req_t          req_x, req_y;
  logic                          busy_x, busy_y, cfg_busy;
  logic [imgscl_pkg::STEP_W-1:0] step_x, step_y;

  assign req_x    = '{start: div_kick, num: sw, den: dw};
  assign req_y    = '{start: div_kick, num: sh, den: dh};
  assign cfg_busy = div_kick || busy_x || busy_y;

  imgscl_step_div u_div_x (.clk(clk), .rst(rst), .req(req_x), .busy(busy_x), .quo(step_x));
  imgscl_step_div u_div_y (.clk(clk), .rst(rst), .req(req_y), .busy(busy_y), .quo(step_y));

  // ---------------------------------------------------------------------
  // Pipeline stage flow control
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_free, s2_free, s3_free, s4_free;
  logic s4_go, s4_done, s4_at_end, s4_need_credit;
  logic in_fire, m_fire;

  assign s4_free = !s4_valid || s4_done;
  assign s3_free = !s3_valid || s4_free;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;

  assign s_axis_tready = s1_free && !cfg_busy && !cfg_we;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // Stage 1: accepted item
  logic                       s1_func;
  logic [imgscl_pkg::POS_W-1:0] s1_px, s1_py;
  imgscl_pkg::pixel_t         s1_pix;
  logic                       s1_keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func <= s_axis_tuser;
      s1_px   <= s_axis_tdata[7:0];
      s1_py   <= s_axis_tdata[15:8];
      s1_pix  <= s_axis_tdata[47:16];
    end
  end

  // Loads outside the store are dropped, and so are samples outside the destination or with a zero size
  always_comb begin
    if (s1_func == imgscl_pkg::FUNC_SAMPLE) begin
      s1_keep = sizes_ok && ({1'b0, s1_px} < dw) && ({1'b0, s1_py} < dh);
    end else begin
      s1_keep = (int'(s1_px) < MAX_DIM) && (int'(s1_py) < MAX_DIM);
    end
  end

  // Stage 2: position times step
  logic                         s2_func;
  logic [AW-1:0]                s2_addr;
  imgscl_pkg::pixel_t           s2_pix;
  logic [imgscl_pkg::CUR_W-1:0] s2_prod_x, s2_prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_func   <= s1_func;
      s2_addr   <= mem_addr(CW'(s1_px), CW'(s1_py));
      s2_pix    <= s1_pix;
      s2_prod_x <= {{(imgscl_pkg::CUR_W-imgscl_pkg::POS_W){1'b0}}, s1_px} * {1'b0, step_x};
      s2_prod_y <= {{(imgscl_pkg::CUR_W-imgscl_pkg::POS_W){1'b0}}, s1_py} * {1'b0, step_y};
    end
  end

  // Stage 3: cursor at the pixel center
  logic                         s3_func;
  logic [AW-1:0]                s3_addr;
  imgscl_pkg::pixel_t           s3_pix;
  logic [imgscl_pkg::CUR_W-1:0] s3_cur_x, s3_cur_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      s3_func  <= s2_func;
      s3_addr  <= s2_addr;
      s3_pix   <= s2_pix;
      s3_cur_x <= {2'b00, step_x[imgscl_pkg::STEP_W-1:1]} - 1'b1 + s2_prod_x;
      s3_cur_y <= {2'b00, step_y[imgscl_pkg::STEP_W-1:1]} - 1'b1 + s2_prod_y;
    end
  end

  // Stage 4: neighbour indices and fractions, then memory issue
  axis_t              ax, ay;
  logic               s4_func, s4_mode;
  logic [AW-1:0]      s4_addr;
  imgscl_pkg::pixel_t s4_pix;
  axis_t              s4_ax, s4_ay;
  logic [1:0]         phase;

  assign ax = split_axis(s3_cur_x, sw, filter_mode);
  assign ay = split_axis(s3_cur_y, sh, filter_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_free) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free && s3_valid) begin
      s4_func <= s3_func;
      s4_mode <= filter_mode;
      s4_addr <= s3_addr;
      s4_pix  <= s3_pix;
      s4_ax   <= ax;
      s4_ay   <= ay;
    end
  end

  // Issue sequencing: one port access per cycle while a sample finds a free result slot, four for a bilinear sample
  logic [QCW-1:0] credit;

  assign s4_at_end      = (s4_func == imgscl_pkg::FUNC_LOAD) ||
                          (s4_mode == imgscl_pkg::FILTER_NEAREST) || (phase == 2'd3);
  assign s4_need_credit = (s4_func == imgscl_pkg::FUNC_SAMPLE) && (phase == 2'd0);
  assign s4_go          = s4_valid && (!s4_need_credit || (credit < QCW'(QDEPTH)));
  assign s4_done        = s4_go && s4_at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (s4_go) begin
      phase <= s4_at_end ? 2'd0 : phase + 2'd1;
    end
  end

  // Result slots reserved at issue, released when the result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({s4_go && s4_need_credit, m_fire})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Port address and weight of the current neighbour
  logic [CW-1:0]                sel_x, sel_y;
  logic [AW-1:0]                mem_a;
  logic                         mem_we, mem_re;
  logic [imgscl_pkg::FR_W:0]    wx, wy;
  logic [imgscl_pkg::WT_W-1:0]  weight;

  always_comb begin
    sel_x  = phase[0] ? s4_ax.i2 : s4_ax.i1;
    sel_y  = phase[1] ? s4_ay.i2 : s4_ay.i1;
    mem_a  = (s4_func == imgscl_pkg::FUNC_LOAD) ? s4_addr : mem_addr(sel_x, sel_y);
    mem_we = s4_go && (s4_func == imgscl_pkg::FUNC_LOAD);
    mem_re = s4_go && (s4_func == imgscl_pkg::FUNC_SAMPLE);
    wx     = phase[0] ? {1'b0, s4_ax.frac} : imgscl_pkg::WEIGHT_ONE - {1'b0, s4_ax.frac};
    wy     = phase[1] ? {1'b0, s4_ay.frac} : imgscl_pkg::WEIGHT_ONE - {1'b0, s4_ay.frac};
    weight = {{(imgscl_pkg::WT_W-imgscl_pkg::FR_W-1){1'b0}}, wx}
           * {{(imgscl_pkg::WT_W-imgscl_pkg::FR_W-1){1'b0}}, wy};
  end

  // Source pixel store, single port
  imgscl_pkg::pixel_t mem [DEPTH];
  imgscl_pkg::pixel_t mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_a] <= s4_pix;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_a];
    end
  end

  // Read stage: weight travels beside the read
  logic                        r_valid, r_first, r_last;
  logic [imgscl_pkg::WT_W-1:0] r_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      r_first  <= (phase == 2'd0);
      r_last   <= s4_at_end;
      r_weight <= weight;
    end
  end

  // Product stage: channel times weight
  logic                         p_valid, p_first, p_last;
  logic [imgscl_pkg::ACC_W-1:0] p_prod [imgscl_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_valid) begin
      p_first <= r_first;
      p_last  <= r_last;
      for (int c = 0; c < imgscl_pkg::CHANNELS; c++) begin
        p_prod[c] <= {{(imgscl_pkg::ACC_W-imgscl_pkg::CH_W){1'b0}},
                      mem_rdata[c*imgscl_pkg::CH_W +: imgscl_pkg::CH_W]}
                   * {{(imgscl_pkg::ACC_W-imgscl_pkg::WT_W){1'b0}}, r_weight};
      end
    end
  end

  // Accumulate stage: sum of weighted neighbours, top byte is the result
  logic [imgscl_pkg::ACC_W-1:0] acc [imgscl_pkg::CHANNELS];
  logic [imgscl_pkg::ACC_W-1:0] sum [imgscl_pkg::CHANNELS];
  imgscl_pkg::pixel_t           push_data;
  logic                         push;

  always_comb begin
    for (int c = 0; c < imgscl_pkg::CHANNELS; c++) begin
      sum[c] = (p_first ? '0 : acc[c]) + p_prod[c];
      push_data[c*imgscl_pkg::CH_W +: imgscl_pkg::CH_W] =
        sum[c][imgscl_pkg::ACC_W-1 -: imgscl_pkg::CH_W];
    end
  end

  assign push = p_valid && p_last;

  always_ff @(posedge clk) begin
    if (p_valid) begin
      for (int c = 0; c < imgscl_pkg::CHANNELS; c++) begin
        acc[c] <= sum[c];
      end
    end
  end

  // Output queue
  imgscl_pkg::pixel_t q_data [QDEPTH];
  logic [QW-1:0]      q_wr, q_rd;
  logic [QCW-1:0]     q_cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[q_wr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (push) begin
        q_wr <= q_wr + 1'b1;
      end
      if (m_fire) begin
        q_rd <= q_rd + 1'b1;
      end
      case ({push, m_fire})
        2'b10:   q_cnt <= q_cnt + 1'b1;
        2'b01:   q_cnt <= q_cnt - 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = (q_cnt != '0);
  assign m_axis_tdata  = q_data[q_rd];

endmodule
